// ===== hw/rtl/cmtrr_pkg.sv =====
// shared widths, register indexes and reset values for the colour mask row run block
`timescale 1ns / 1ps

package cmtrr_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned BOUND_W = 9;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned IDX_W   = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [BOUND_W-1:0] bound_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   reg_idx_t;

  localparam reg_idx_t REG_HUE_LOW  = 3'd0;
  localparam reg_idx_t REG_HUE_HIGH = 3'd1;
  localparam reg_idx_t REG_SAT_LOW  = 3'd2;
  localparam reg_idx_t REG_SAT_HIGH = 3'd3;
  localparam reg_idx_t REG_VAL_LOW  = 3'd4;
  localparam reg_idx_t REG_VAL_HIGH = 3'd5;
  localparam reg_idx_t REG_MIN_ROW  = 3'd6;

  localparam bound_t RST_HUE_LOW  = 9'd90;
  localparam bound_t RST_HUE_HIGH = 9'd110;
  localparam bound_t RST_SAT_LOW  = 9'd220;
  localparam bound_t RST_SAT_HIGH = 9'd256;
  localparam bound_t RST_VAL_LOW  = 9'd160;
  localparam bound_t RST_VAL_HIGH = 9'd255;
  localparam cnt_t   RST_MIN_ROW  = 11'd10;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? CNT_MAX : cnt_t'(v + 1'b1);
  endfunction

endpackage

// ===== hw/rtl/color_mask_tallest_row_run.sv =====
// top level: hsv colour mask, per-row marked count and longest run of significant rows
`timescale 1ns / 1ps

// Pixels enter in raster order on the in_ channel, one word per cycle, with row_end on
// the last pixel of a row and frame_end on the last pixel of a frame (it also ends the
// row). A word is taken at a clock edge with in_valid high and in_stall low.
// Each pixel is registered, then the window compares, the row count, the run counter
// and the longest-run compare are done combinationally from that register. Only a
// frame_end pixel gives a result: one tallest_run word on the out_ channel, moved
// from the pixel register into the output register. Throughput is one pixel per
// cycle while in_stall is low; the only loop updates the row, run and longest counters.
// The result sits in an output register; while it waits under out_stall, pixels keep
// flowing until the next frame_end pixel reaches the pipeline register, where it holds
// and in_stall is raised.
// The cfg_ channel writes one window bound or the row threshold per word (index 0..6,
// other indexes ignored); cfg_ready is always high. Writes are meant for idle periods.
// Synchronous reset loads the default windows and threshold, clears the counters and
// empties the pipeline; no clearing pass is needed.
module color_mask_tallest_row_run (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cmtrr_pkg::PIX_W-1:0]         in_hue,
  input  logic [cmtrr_pkg::PIX_W-1:0]         in_saturation,
  input  logic [cmtrr_pkg::PIX_W-1:0]         in_brightness,
  input  logic                                in_row_end,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cmtrr_pkg::CNT_W-1:0]         out_tallest_run,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cmtrr_pkg::IDX_W-1:0]         cfg_index,
  input  logic [cmtrr_pkg::CNT_W-1:0]         cfg_data
);

  cmtrr_pkg::bound_t hue_low_r, hue_high_r, sat_low_r, sat_high_r, val_low_r, val_high_r;
  cmtrr_pkg::cnt_t   min_row_r;

  logic                          s1_valid_r;
  logic [cmtrr_pkg::PIX_W-1:0]   s1_hue_r, s1_sat_r, s1_val_r;
  logic                          s1_row_end_r, s1_frame_r;

  cmtrr_pkg::cnt_t row_cnt_r, row_cnt_nxt;
  cmtrr_pkg::cnt_t run_r, run_nxt;
  cmtrr_pkg::cnt_t longest_r, longest_nxt;

  logic            out_valid_r;
  cmtrr_pkg::cnt_t out_run_r;

  logic            out_free, s1_adv, in_acc;
  logic            mark, row_done, significant;
  cmtrr_pkg::cnt_t cnt_incl, run_inc, longest_upd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= cmtrr_pkg::RST_HUE_LOW;
      hue_high_r <= cmtrr_pkg::RST_HUE_HIGH;
      sat_low_r  <= cmtrr_pkg::RST_SAT_LOW;
      sat_high_r <= cmtrr_pkg::RST_SAT_HIGH;
      val_low_r  <= cmtrr_pkg::RST_VAL_LOW;
      val_high_r <= cmtrr_pkg::RST_VAL_HIGH;
      min_row_r  <= cmtrr_pkg::RST_MIN_ROW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cmtrr_pkg::REG_HUE_LOW:  hue_low_r  <= cfg_data[cmtrr_pkg::BOUND_W-1:0];
        cmtrr_pkg::REG_HUE_HIGH: hue_high_r <= cfg_data[cmtrr_pkg::BOUND_W-1:0];
        cmtrr_pkg::REG_SAT_LOW:  sat_low_r  <= cfg_data[cmtrr_pkg::BOUND_W-1:0];
        cmtrr_pkg::REG_SAT_HIGH: sat_high_r <= cfg_data[cmtrr_pkg::BOUND_W-1:0];
        cmtrr_pkg::REG_VAL_LOW:  val_low_r  <= cfg_data[cmtrr_pkg::BOUND_W-1:0];
        cmtrr_pkg::REG_VAL_HIGH: val_high_r <= cfg_data[cmtrr_pkg::BOUND_W-1:0];
        cmtrr_pkg::REG_MIN_ROW:  min_row_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && (!s1_frame_r || out_free);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_tallest_run = out_run_r;

  // pixel register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hue_r     <= in_hue;
      s1_sat_r     <= in_saturation;
      s1_val_r     <= in_brightness;
      s1_row_end_r <= in_row_end;
      s1_frame_r   <= in_frame_end;
    end
  end

  // mask, row count and run tracking
  always_comb begin
    mark = ({1'b0, s1_hue_r} >= hue_low_r) && ({1'b0, s1_hue_r} <= hue_high_r) &&
           ({1'b0, s1_sat_r} >= sat_low_r) && ({1'b0, s1_sat_r} <= sat_high_r) &&
           ({1'b0, s1_val_r} >= val_low_r) && ({1'b0, s1_val_r} <= val_high_r);
    cnt_incl    = mark ? cmtrr_pkg::sat_inc(row_cnt_r) : row_cnt_r;
    row_done    = s1_row_end_r || s1_frame_r;
    significant = cnt_incl >= min_row_r;
    run_inc     = cmtrr_pkg::sat_inc(run_r);
    longest_upd = (run_inc > longest_r) ? run_inc : longest_r;

    row_cnt_nxt = cnt_incl;
    run_nxt     = run_r;
    longest_nxt = longest_r;
    if (row_done) begin
      row_cnt_nxt = '0;
      if (significant) begin
        run_nxt     = run_inc;
        longest_nxt = longest_upd;
      end else begin
        run_nxt = '0;
      end
    end
    if (s1_frame_r) begin
      run_nxt     = '0;
      longest_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      run_r     <= '0;
      longest_r <= '0;
    end else if (s1_adv) begin
      row_cnt_r <= row_cnt_nxt;
      run_r     <= run_nxt;
      longest_r <= longest_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_frame_r) begin
      out_run_r <= (row_done && significant) ? longest_upd : longest_r;
    end
  end

  a_frame_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_frame_r) |=> out_valid_r)
    else $error("frame end word not loaded into result register");

  a_stall_only_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_frame_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked frame end word");

  a_frame_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_frame_r) |=> (row_cnt_r == '0 && run_r == '0 && longest_r == '0))
    else $error("state not cleared after frame end");

  a_run_within_longest: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (run_r <= longest_r))
    else $error("current run exceeds longest run");

endmodule

// ===== test/color_mask_tallest_row_run_tb.sv =====
// testbench for color_mask_tallest_row_run: random hsv frames checked against a tallest-run predictor
`timescale 1ns / 1ps

module color_mask_tallest_row_run_tb;
  import cmtrr_pkg::*;

  localparam int       RANDOM_PIXELS = 1500;
  localparam int       SAT_LEN       = 2100;
  localparam int       HOLD_CYCLES   = 300;
  localparam int       DRAIN_CYCLES  = 4;
  localparam int       TIMEOUT_NS    = 8_000_000;
  localparam reg_idx_t REG_SPARE     = 3'd7;
  localparam bound_t   BOUND_TOP     = 9'd256;
  localparam bound_t   PIX_TOP       = 9'd255;

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] bri;
    logic             row_end;
    logic             frame_end;
  } pixel_t;

  class run_scoreboard;
    bound_t hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
    cnt_t   min_row;
    cnt_t   row_count, run_len, best_run;
    cnt_t   expected_runs[$];
    int     mismatches;

    function new();
      hue_lo = RST_HUE_LOW;
      hue_hi = RST_HUE_HIGH;
      sat_lo = RST_SAT_LOW;
      sat_hi = RST_SAT_HIGH;
      val_lo = RST_VAL_LOW;
      val_hi = RST_VAL_HIGH;
      min_row = RST_MIN_ROW;
      row_count = '0;
      run_len = '0;
      best_run = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, cnt_t data);
      case (idx)
        REG_HUE_LOW:  hue_lo = data[BOUND_W-1:0];
        REG_HUE_HIGH: hue_hi = data[BOUND_W-1:0];
        REG_SAT_LOW:  sat_lo = data[BOUND_W-1:0];
        REG_SAT_HIGH: sat_hi = data[BOUND_W-1:0];
        REG_VAL_LOW:  val_lo = data[BOUND_W-1:0];
        REG_VAL_HIGH: val_hi = data[BOUND_W-1:0];
        REG_MIN_ROW:  min_row = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_t p);
      if (p.hue >= hue_lo && p.hue <= hue_hi && p.sat >= sat_lo && p.sat <= sat_hi &&
          p.bri >= val_lo && p.bri <= val_hi && row_count != CNT_MAX)
        row_count++;
      if (p.row_end || p.frame_end) begin
        if (row_count >= min_row) begin
          if (run_len != CNT_MAX) run_len++;
          if (run_len > best_run) best_run = run_len;
        end else begin
          run_len = '0;
        end
        row_count = '0;
      end
      if (p.frame_end) begin
        expected_runs.push_back(best_run);
        row_count = '0;
        run_len = '0;
        best_run = '0;
      end
    endfunction

    function void check_run(cnt_t got);
      cnt_t want;
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tallest_run word: got %0d", got);
      end else begin
        want = expected_runs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tallest_run mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_hue = '0;
  logic [PIX_W-1:0] in_saturation = '0;
  logic [PIX_W-1:0] in_brightness = '0;
  logic             in_row_end = 1'b0;
  logic             in_frame_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CNT_W-1:0] out_tallest_run;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;

  run_scoreboard sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_cycles = 0;
  int pixels_sent = 0;

  color_mask_tallest_row_run dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_run(out_tallest_run);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("** color_mask_tallest_row_run: FAILED **");
    $finish;
  end

  // receiver: random stalls per word, one long hold-off on request
  initial begin
    int w;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else begin
        w = rx_idle ? $urandom_range(0, 9) : 0;
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  function automatic cnt_t with_junk(bound_t b);
    logic [1:0] junk;
    junk = 2'($urandom);
    return {junk, b};
  endfunction

  function automatic logic [PIX_W-1:0] channel(bound_t lo, bound_t hi, bit want);
    bound_t top;
    top = (hi > PIX_TOP) ? PIX_TOP : hi;
    if (want && lo <= top) begin
      case ($urandom_range(0, 3))
        0: return lo[PIX_W-1:0];
        1: return top[PIX_W-1:0];
        default: return PIX_W'($urandom_range(lo, top));
      endcase
    end
    // near misses just outside the window
    if ($urandom_range(0, 3) == 0) begin
      if (lo > 0 && lo <= PIX_TOP + 1) return PIX_W'(lo - 1);
      if (hi < PIX_TOP) return PIX_W'(hi + 1);
    end
    return PIX_W'($urandom);
  endfunction

  function automatic pixel_t make_pixel(int dens);
    pixel_t p;
    bit want;
    want = $urandom_range(0, 99) < dens;
    p.hue = channel(sb.hue_lo, sb.hue_hi, want);
    p.sat = channel(sb.sat_lo, sb.sat_hi, want);
    p.bri = channel(sb.val_lo, sb.val_hi, want);
    p.row_end = 1'b0;
    p.frame_end = 1'b0;
    return p;
  endfunction

  function automatic pixel_t px(logic [PIX_W-1:0] h, s, v, logic re, fe);
    pixel_t p;
    p.hue = h;
    p.sat = s;
    p.bri = v;
    p.row_end = re;
    p.frame_end = fe;
    return p;
  endfunction

  function automatic void pick_window(output bound_t lo, output bound_t hi);
    case ($urandom_range(0, 9))
      0: begin
        lo = '0;
        hi = BOUND_TOP;
      end
      1: begin
        lo = bound_t'($urandom_range(1, BOUND_TOP));
        hi = bound_t'($urandom_range(0, lo - 1));
      end
      2: begin
        lo = bound_t'($urandom_range(0, PIX_TOP));
        hi = lo;
      end
      3: begin
        lo = BOUND_TOP;
        hi = BOUND_TOP;
      end
      default: begin
        lo = bound_t'($urandom_range(0, PIX_TOP));
        hi = bound_t'($urandom_range(lo, BOUND_TOP));
      end
    endcase
  endfunction

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_hue <= p.hue;
    in_saturation <= p.sat;
    in_brightness <= p.bri;
    in_row_end <= p.row_end;
    in_frame_end <= p.frame_end;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_put(input reg_idx_t idx, input cnt_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_config(input bound_t hl, hh, sl, sh, vl, vh, input cnt_t mr);
    cfg_put(REG_HUE_LOW, with_junk(hl));
    cfg_put(REG_HUE_HIGH, with_junk(hh));
    cfg_put(REG_SAT_LOW, with_junk(sl));
    cfg_put(REG_SAT_HIGH, with_junk(sh));
    if ($urandom_range(0, 3) == 0) cfg_put(REG_SPARE, cnt_t'($urandom));
    cfg_put(REG_VAL_LOW, with_junk(vl));
    cfg_put(REG_VAL_HIGH, with_junk(vh));
    cfg_put(REG_MIN_ROW, mr);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    bound_t hl, hh, sl, sh, vl, vh;
    cnt_t   mr;
    pick_window(hl, hh);
    pick_window(sl, sh);
    pick_window(vl, vh);
    case ($urandom_range(0, 9))
      0: mr = '0;
      1: mr = CNT_MAX;
      2: mr = cnt_t'($urandom);
      default: mr = cnt_t'($urandom_range(0, 8));
    endcase
    load_config(hl, hh, sl, sh, vl, vh, mr);
  endtask

  task automatic send_frame(input int rows, input int max_cols, input bit ragged);
    int     len, dens;
    pixel_t p;
    for (int r = 0; r < rows; r++) begin
      len = $urandom_range(1, max_cols);
      dens = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(0, 100);
      for (int c = 0; c < len; c++) begin
        p = make_pixel(dens);
        p.frame_end = (r == rows - 1) && (c == len - 1);
        if (ragged) p.row_end = ($urandom_range(0, 3) == 0);
        else if (p.frame_end) p.row_end = $urandom_range(0, 1);
        else p.row_end = (c == len - 1);
        send_pixel(p);
      end
    end
  endtask

  initial begin
    int     base;
    pixel_t p;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset windows: lone frame-end words and a row right on the window edges
    send_pixel(px(8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
    for (int i = 0; i < 10; i++) begin
      if (i % 2 == 0) send_pixel(px(8'd90, 8'd220, 8'd160, 1'b0, i == 9));
      else send_pixel(px(8'd110, 8'd255, 8'd255, 1'b0, i == 9));
    end
    wait_drained();

    // one pixel per row, edges in and just out, run ending at frame bottom
    load_config(RST_HUE_LOW, RST_HUE_HIGH, RST_SAT_LOW, RST_SAT_HIGH,
                RST_VAL_LOW, RST_VAL_HIGH, 11'd1);
    send_pixel(px(8'd90, 8'd220, 8'd160, 1'b1, 1'b0));
    send_pixel(px(8'd110, 8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(px(8'd89, 8'd220, 8'd160, 1'b1, 1'b0));
    send_pixel(px(8'd100, 8'd220, 8'd160, 1'b1, 1'b0));
    send_pixel(px(8'd111, 8'd220, 8'd160, 1'b1, 1'b0));
    send_pixel(px(8'd100, 8'd219, 8'd160, 1'b1, 1'b0));
    send_pixel(px(8'd100, 8'd230, 8'd159, 1'b1, 1'b0));
    send_pixel(px(8'd100, 8'd230, 8'd200, 1'b0, 1'b1));
    wait_drained();

    // empty hue window with zero threshold, then with threshold one
    load_config(9'd200, 9'd100, RST_SAT_LOW, RST_SAT_HIGH, RST_VAL_LOW, RST_VAL_HIGH, '0);
    send_pixel(px(8'd150, 8'd230, 8'd200, 1'b1, 1'b0));
    send_pixel(px(8'd150, 8'd230, 8'd200, 1'b0, 1'b1));
    wait_drained();
    load_config(9'd200, 9'd100, RST_SAT_LOW, RST_SAT_HIGH, RST_VAL_LOW, RST_VAL_HIGH, 11'd1);
    send_pixel(px(8'd150, 8'd230, 8'd200, 1'b1, 1'b1));
    wait_drained();

    // back-pressure: long receiver hold-off while short frames keep coming
    load_config('0, BOUND_TOP, '0, BOUND_TOP, '0, BOUND_TOP, 11'd1);
    tx_idle = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (12) send_frame($urandom_range(1, 2), 3, 1'b0);
    wait_drained();

    base = pixels_sent;
    while (pixels_sent < base + RANDOM_PIXELS) begin
      wait_drained();
      if ($urandom_range(0, 3) != 0) random_config();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 6))
        send_frame($urandom_range(1, 6), $urandom_range(1, 10), $urandom_range(0, 9) == 0);
    end
    wait_drained();

    // saturating row count, then saturating run length
    tx_idle = ($urandom_range(0, 1) != 0);
    rx_idle = 1'b1;
    load_config('0, BOUND_TOP, '0, BOUND_TOP, '0, BOUND_TOP, CNT_MAX);
    for (int i = 0; i < SAT_LEN; i++) begin
      p = make_pixel(100);
      p.frame_end = (i == SAT_LEN - 1);
      send_pixel(p);
    end
    wait_drained();
    load_config('0, BOUND_TOP, '0, BOUND_TOP, '0, BOUND_TOP, '0);
    for (int i = 0; i < SAT_LEN; i++) begin
      p = make_pixel($urandom_range(0, 100));
      p.row_end = 1'b1;
      p.frame_end = (i == SAT_LEN - 1);
      send_pixel(p);
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.mismatches == 0 && sb.expected_runs.size() == 0) begin
      $display("** color_mask_tallest_row_run: PASSED **");
    end else begin
      $display("** color_mask_tallest_row_run: FAILED **");
    end
    $finish;
  end

endmodule

// ===== color_mask_tallest_row_run.f =====
hw/rtl/cmtrr_pkg.sv
hw/rtl/color_mask_tallest_row_run.sv
test/color_mask_tallest_row_run_tb.sv
